@@ rtl/bonf_pkg.sv @@
package bonf_pkg;

  localparam int POS_W = 32;
  localparam int EXT_W = 31;
  localparam int IDX_OUT_W = 5;

  localparam logic CMD_ADD = 1'b0;
  localparam logic CMD_CLEAR = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FULL,
    ST_FIN
  } ctrl_state_e;

  typedef struct packed {
    logic load;
    logic clear;
    logic step;
    logic emit_pend;
    logic emit_last;
    logic emit_none;
    logic emit_full;
    logic store;
  } dp_cmd_t;

  typedef struct packed {
    logic full;
    logic scan_done;
    logic cmp_vld;
    logic hit;
    logic pend_vld;
    logic out_free;
  } dp_stat_t;

endpackage

@@ rtl/bonf_if.sv @@
interface bonf_req_if
  import bonf_pkg::*;
;
  logic                    valid;
  logic                    ready;
  logic                    command;
  logic signed [POS_W-1:0] x_pos;
  logic signed [POS_W-1:0] y_pos;
  logic signed [POS_W-1:0] z_pos;
  logic [EXT_W-1:0]        x_extent;
  logic [EXT_W-1:0]        y_extent;
  logic [EXT_W-1:0]        z_extent;

  modport source (
    output valid, command, x_pos, y_pos, z_pos, x_extent, y_extent, z_extent,
    input  ready
  );
  modport sink (
    input  valid, command, x_pos, y_pos, z_pos, x_extent, y_extent, z_extent,
    output ready
  );
endinterface

interface bonf_res_if
  import bonf_pkg::*;
;
  logic                 valid;
  logic                 ready;
  logic [IDX_OUT_W-1:0] new_index;
  logic [IDX_OUT_W-1:0] other_index;
  logic                 found;
  logic                 full_error;
  logic                 last;

  modport source (
    output valid, new_index, other_index, found, full_error, last,
    input  ready
  );
  modport sink (
    input  valid, new_index, other_index, found, full_error, last,
    output ready
  );
endinterface

@@ rtl/bonf_ram.sv @@
module bonf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/bonf_dp.sv @@
module bonf_dp
  import bonf_pkg::*;
#(
  parameter int MAX_BOXES = 32,
  parameter int COORD_BITS = 32
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  dp_cmd_t                 cmd_i,
  output dp_stat_t                stat_o,
  input  logic signed [POS_W-1:0] x_pos_i,
  input  logic signed [POS_W-1:0] y_pos_i,
  input  logic signed [POS_W-1:0] z_pos_i,
  input  logic [EXT_W-1:0]        x_extent_i,
  input  logic [EXT_W-1:0]        y_extent_i,
  input  logic [EXT_W-1:0]        z_extent_i,
  input  logic                    out_ready_i,
  output logic                    out_valid_o,
  output logic [IDX_OUT_W-1:0]    new_index_o,
  output logic [IDX_OUT_W-1:0]    other_index_o,
  output logic                    found_o,
  output logic                    full_error_o,
  output logic                    last_o
);

  localparam int Cw = (COORD_BITS < 32) ? COORD_BITS : 32;
  localparam int EndW = Cw + 1;
  localparam int WordW = 6 * EndW;
  localparam int IdxW = $clog2(MAX_BOXES);
  localparam int CntW = $clog2(MAX_BOXES + 1);

  typedef struct packed {
    logic signed [EndW-1:0] x_pos;
    logic signed [EndW-1:0] x_end;
    logic signed [EndW-1:0] y_pos;
    logic signed [EndW-1:0] y_end;
    logic signed [EndW-1:0] z_pos;
    logic signed [EndW-1:0] z_end;
  } box_t;

  function automatic logic signed [EndW-1:0] pos_of(logic [POS_W-1:0] v);
    return $signed({v[Cw-1], v[Cw-1:0]});
  endfunction

  function automatic logic signed [EndW-1:0] end_of(logic [POS_W-1:0] p, logic [EXT_W-1:0] e);
    return pos_of(p) + $signed({2'b00, e[Cw-2:0]});
  endfunction

  function automatic logic meets(logic signed [EndW-1:0] pa, logic signed [EndW-1:0] ea,
                                 logic signed [EndW-1:0] pb, logic signed [EndW-1:0] eb);
    return (pa <= eb) && (pb <= ea);
  endfunction

  box_t            box_q;
  box_t            box_d;
  box_t            stored;
  logic [WordW-1:0] rd_word;
  logic [CntW-1:0] count_q, count_d;
  logic [CntW-1:0] rd_idx_q, rd_idx_d;
  logic [IdxW-1:0] cmp_idx_q, cmp_idx_d;
  logic            cmp_vld_q, cmp_vld_d;
  logic [IdxW-1:0] pend_idx_q, pend_idx_d;
  logic            pend_vld_q, pend_vld_d;
  logic            out_valid_q, out_valid_d;
  logic            out_load;
  logic            out_free;
  logic            scan_done;
  logic            hit;
  logic            rd_en;

  logic [IDX_OUT_W-1:0] new_index_q, new_index_d;
  logic [IDX_OUT_W-1:0] other_index_q, other_index_d;
  logic                 found_q, found_d;
  logic                 full_error_q, full_error_d;
  logic                 last_q, last_d;

  assign box_d.x_pos = pos_of(x_pos_i);
  assign box_d.x_end = end_of(x_pos_i, x_extent_i);
  assign box_d.y_pos = pos_of(y_pos_i);
  assign box_d.y_end = end_of(y_pos_i, y_extent_i);
  assign box_d.z_pos = pos_of(z_pos_i);
  assign box_d.z_end = end_of(z_pos_i, z_extent_i);

  assign scan_done = (rd_idx_q == count_q);
  assign rd_en     = cmd_i.step && !scan_done;
  assign out_free  = !out_valid_q || out_ready_i;
  assign out_load  = cmd_i.emit_pend || cmd_i.emit_none || cmd_i.emit_full;

  bonf_ram #(
    .WIDTH(WordW),
    .DEPTH(MAX_BOXES)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (cmd_i.store),
    .waddr_i(count_q[IdxW-1:0]),
    .wdata_i(box_q),
    .re_i   (rd_en),
    .raddr_i(rd_idx_q[IdxW-1:0]),
    .rdata_o(rd_word)
  );

  assign stored = box_t'(rd_word);
  assign hit = meets(box_q.x_pos, box_q.x_end, stored.x_pos, stored.x_end) &&
               meets(box_q.y_pos, box_q.y_end, stored.y_pos, stored.y_end) &&
               meets(box_q.z_pos, box_q.z_end, stored.z_pos, stored.z_end);

  always_comb begin
    count_d     = count_q;
    rd_idx_d    = rd_idx_q;
    cmp_idx_d   = cmp_idx_q;
    cmp_vld_d   = cmp_vld_q;
    pend_idx_d  = pend_idx_q;
    pend_vld_d  = pend_vld_q;
    out_valid_d = out_valid_q;

    if (cmd_i.clear) begin
      count_d = '0;
    end else if (cmd_i.store) begin
      count_d = count_q + CntW'(1);
    end

    if (cmd_i.load) begin
      rd_idx_d   = '0;
      cmp_vld_d  = 1'b0;
      pend_vld_d = 1'b0;
    end else if (cmd_i.step) begin
      if (cmp_vld_q && hit) begin
        pend_idx_d = cmp_idx_q;
        pend_vld_d = 1'b1;
      end
      cmp_vld_d = !scan_done;
      if (!scan_done) begin
        cmp_idx_d = rd_idx_q[IdxW-1:0];
        rd_idx_d  = rd_idx_q + CntW'(1);
      end
    end

    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_comb begin
    new_index_d   = IDX_OUT_W'(count_q);
    other_index_d = IDX_OUT_W'(pend_idx_q);
    found_d       = 1'b1;
    full_error_d  = 1'b0;
    last_d        = cmd_i.emit_last;
    if (cmd_i.emit_full) begin
      new_index_d   = '0;
      other_index_d = '0;
      found_d       = 1'b0;
      full_error_d  = 1'b1;
      last_d        = 1'b1;
    end else if (cmd_i.emit_none) begin
      other_index_d = '0;
      found_d       = 1'b0;
      last_d        = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      rd_idx_q    <= '0;
      cmp_vld_q   <= 1'b0;
      pend_vld_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      rd_idx_q    <= rd_idx_d;
      cmp_vld_q   <= cmp_vld_d;
      pend_vld_q  <= pend_vld_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      box_q <= box_d;
    end
    cmp_idx_q  <= cmp_idx_d;
    pend_idx_q <= pend_idx_d;
    if (out_load) begin
      new_index_q   <= new_index_d;
      other_index_q <= other_index_d;
      found_q       <= found_d;
      full_error_q  <= full_error_d;
      last_q        <= last_d;
    end
  end

  assign stat_o.full      = (count_q == CntW'(MAX_BOXES));
  assign stat_o.scan_done = scan_done;
  assign stat_o.cmp_vld   = cmp_vld_q;
  assign stat_o.hit       = hit;
  assign stat_o.pend_vld  = pend_vld_q;
  assign stat_o.out_free  = out_free;

  assign out_valid_o   = out_valid_q;
  assign new_index_o   = new_index_q;
  assign other_index_o = other_index_q;
  assign found_o       = found_q;
  assign full_error_o  = full_error_q;
  assign last_o        = last_q;

endmodule

@@ rtl/bonf_ctrl.sv @@
module bonf_ctrl
  import bonf_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  input  logic     command_i,
  output logic     in_ready_o,
  input  dp_stat_t stat_i,
  output dp_cmd_t  cmd_o
);

  ctrl_state_e state_q, state_d;
  logic        push_pend;

  assign push_pend = stat_i.cmp_vld && stat_i.hit && stat_i.pend_vld;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          if (command_i == CMD_CLEAR) begin
            cmd_o.clear = 1'b1;
          end else if (stat_i.full) begin
            state_d = ST_FULL;
          end else begin
            cmd_o.load = 1'b1;
            state_d    = ST_SCAN;
          end
        end
      end
      ST_FULL: begin
        if (stat_i.out_free) begin
          cmd_o.emit_full = 1'b1;
          state_d         = ST_IDLE;
        end
      end
      ST_SCAN: begin
        if (!stat_i.cmp_vld && stat_i.scan_done) begin
          state_d = ST_FIN;
        end else if (!push_pend || stat_i.out_free) begin
          cmd_o.step      = 1'b1;
          cmd_o.emit_pend = push_pend;
        end
      end
      ST_FIN: begin
        if (stat_i.out_free) begin
          cmd_o.emit_pend = stat_i.pend_vld;
          cmd_o.emit_last = stat_i.pend_vld;
          cmd_o.emit_none = !stat_i.pend_vld;
          cmd_o.store     = 1'b1;
          state_d         = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

@@ rtl/box_overlap_neighbor_finder.sv @@
// Reports which stored axis-aligned boxes touch or overlap each newly added
// box, where touching faces, edges or corners count, and then stores the new
// box in the next free slot. A clear item empties the set, and an add to a
// full set gives a single result with full_error set. The stored boxes sit
// in one memory with a single read port, so an add item takes the box, reads
// the stored boxes one at a time, compares the last one read, closes the
// scan and then writes the new box. A result that the sink does not take in
// time stalls the scan until the output register frees up.
module box_overlap_neighbor_finder
  import bonf_pkg::*;
#(
  parameter int MAX_BOXES = 32,
  parameter int COORD_BITS = 32
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  bonf_req_if.sink  req_i,
  bonf_res_if.source res_o
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  bonf_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(req_i.valid),
    .command_i (req_i.command),
    .in_ready_o(req_i.ready),
    .stat_i    (stat),
    .cmd_o     (cmd)
  );

  bonf_dp #(
    .MAX_BOXES (MAX_BOXES),
    .COORD_BITS(COORD_BITS)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .stat_o       (stat),
    .x_pos_i      (req_i.x_pos),
    .y_pos_i      (req_i.y_pos),
    .z_pos_i      (req_i.z_pos),
    .x_extent_i   (req_i.x_extent),
    .y_extent_i   (req_i.y_extent),
    .z_extent_i   (req_i.z_extent),
    .out_ready_i  (res_o.ready),
    .out_valid_o  (res_o.valid),
    .new_index_o  (res_o.new_index),
    .other_index_o(res_o.other_index),
    .found_o      (res_o.found),
    .full_error_o (res_o.full_error),
    .last_o       (res_o.last)
  );

endmodule

@@ tb/sv/box_overlap_neighbor_finder_test.sv @@
`timescale 1ns / 100ps

module box_overlap_neighbor_finder_test;
  import bonf_pkg::*;

  localparam int MAX_SLOTS = 32;
  localparam int RANDOM_ADDS = 340;
  localparam int IDLE_LIMIT = 3000;
  localparam int SETTLE_CYCLES = 80;
  localparam int PRINT_CAP = 40;

  typedef struct packed {
    logic                    command;
    logic signed [POS_W-1:0] x_pos;
    logic signed [POS_W-1:0] y_pos;
    logic signed [POS_W-1:0] z_pos;
    logic [EXT_W-1:0]        x_extent;
    logic [EXT_W-1:0]        y_extent;
    logic [EXT_W-1:0]        z_extent;
  } box_req_t;

  typedef struct packed {
    logic [IDX_OUT_W-1:0] new_index;
    logic [IDX_OUT_W-1:0] other_index;
    logic                 found;
    logic                 full_error;
    logic                 last;
  } pair_result_t;

  typedef struct {
    box_req_t     box;
    int unsigned  reps;
    bit           typed;
    pair_result_t want;
  } stim_row_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  bonf_req_if req_if ();
  bonf_res_if res_if ();

  box_overlap_neighbor_finder #(
    .MAX_BOXES (MAX_SLOTS),
    .COORD_BITS(POS_W)
  ) u_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req_if),
    .res_o (res_if)
  );

  always #2 clk_i = ~clk_i;

  // Model of the stored set: closed intervals [lo, hi] per slot and axis.
  longint slot_lo[MAX_SLOTS][3];
  longint slot_hi[MAX_SLOTS][3];
  int     stored_boxes;

  pair_result_t expected_results[$];
  int mismatches;
  int adds_sent;
  int clears_sent;
  int results_checked;
  int full_seen;
  int pairs_seen;
  int widest_item;
  int quiet_cycles;
  bit calm_sender;
  bit calm_sink;

  function automatic pair_result_t mk_result(input int ni, input int oi, input bit fnd,
                                             input bit full, input bit lst);
    pair_result_t r;
    r.new_index = IDX_OUT_W'(ni);
    r.other_index = IDX_OUT_W'(oi);
    r.found = fnd;
    r.full_error = full;
    r.last = lst;
    return r;
  endfunction

  function automatic box_req_t mk_box(input logic cmd, input logic [POS_W-1:0] x,
                                      input logic [POS_W-1:0] y, input logic [POS_W-1:0] z,
                                      input logic [EXT_W-1:0] ex, input logic [EXT_W-1:0] ey,
                                      input logic [EXT_W-1:0] ez);
    box_req_t b;
    b.command = cmd;
    b.x_pos = x;
    b.y_pos = y;
    b.z_pos = z;
    b.x_extent = ex;
    b.y_extent = ey;
    b.z_extent = ez;
    return b;
  endfunction

  // Updates the modeled set and returns every result the item should cause.
  function automatic void find_neighbors(input box_req_t b, output pair_result_t hits[$]);
    longint lo[3];
    longint hi[3];
    bit     touch;
    hits = {};
    if (b.command == CMD_CLEAR) begin
      stored_boxes = 0;
      return;
    end
    if (stored_boxes >= MAX_SLOTS) begin
      hits.insert(hits.size(), mk_result(0, 0, 1'b0, 1'b1, 1'b1));
      return;
    end
    lo[0] = longint'($signed(b.x_pos));
    lo[1] = longint'($signed(b.y_pos));
    lo[2] = longint'($signed(b.z_pos));
    hi[0] = lo[0] + longint'(b.x_extent);
    hi[1] = lo[1] + longint'(b.y_extent);
    hi[2] = lo[2] + longint'(b.z_extent);
    for (int i = 0; i < stored_boxes; i++) begin
      touch = 1'b1;
      for (int a = 0; a < 3; a++) begin
        if (lo[a] > slot_hi[i][a] || slot_lo[i][a] > hi[a]) touch = 1'b0;
      end
      if (touch) hits.insert(hits.size(), mk_result(stored_boxes, i, 1'b1, 1'b0, 1'b0));
    end
    if (hits.size() == 0) begin
      hits.insert(hits.size(), mk_result(stored_boxes, 0, 1'b0, 1'b0, 1'b1));
    end else begin
      hits[hits.size()-1].last = 1'b1;
    end
    for (int a = 0; a < 3; a++) begin
      slot_lo[stored_boxes][a] = lo[a];
      slot_hi[stored_boxes][a] = hi[a];
    end
    stored_boxes++;
  endfunction

  function automatic box_req_t random_box(input int style);
    logic [POS_W-1:0] pos[3];
    logic [EXT_W-1:0] ext[3];
    for (int a = 0; a < 3; a++) begin
      case (style)
        0: begin
          pos[a] = $urandom();
          ext[a] = EXT_W'($urandom());
        end
        1: begin
          pos[a] = $urandom_range(0, 12) - 6;
          ext[a] = EXT_W'($urandom_range(0, 4));
        end
        2: begin
          pos[a] = $urandom_range(0, 2 ** 21) - 2 ** 20;
          ext[a] = EXT_W'($urandom_range(0, 2 ** 20));
        end
        default: begin
          pos[a] = $urandom_range(0, 1) ? 32'h7FFF_FFFF - $urandom_range(0, 255)
                                        : 32'h8000_0000 + $urandom_range(0, 255);
          ext[a] = EXT_W'($urandom_range(0, 1) ? 32'h7FFF_FFFF - $urandom_range(0, 255)
                                               : $urandom_range(0, 255));
        end
      endcase
    end
    return mk_box(CMD_ADD, pos[0], pos[1], pos[2], ext[0], ext[1], ext[2]);
  endfunction

  task automatic report_mismatch(input string msg);
    mismatches++;
    if (mismatches <= PRINT_CAP) $display("%0t MISMATCH: %s", $realtime, msg);
  endtask

  task automatic check_result(input pair_result_t got);
    pair_result_t want;
    if (expected_results.size() == 0) begin
      report_mismatch($sformatf("result with none expected: new %0d other %0d fnd %0b",
                                got.new_index, got.other_index, got.found));
      return;
    end
    want = expected_results.pop_front();
    results_checked++;
    if (got.new_index !== want.new_index)
      report_mismatch($sformatf("new_index got %0d expected %0d", got.new_index,
                                want.new_index));
    if (got.other_index !== want.other_index)
      report_mismatch($sformatf("other_index got %0d expected %0d", got.other_index,
                                want.other_index));
    if (got.found !== want.found)
      report_mismatch($sformatf("found got %0b expected %0b", got.found, want.found));
    if (got.full_error !== want.full_error)
      report_mismatch($sformatf("full_error got %0b expected %0b", got.full_error,
                                want.full_error));
    if (got.last !== want.last)
      report_mismatch($sformatf("last got %0b expected %0b", got.last, want.last));
  endtask

  task automatic send_box(input box_req_t b, input bit typed, input pair_result_t want);
    pair_result_t hits[$];
    int unsigned  gap;
    gap = calm_sender ? 0 : $urandom_range(0, 5);
    if (gap != 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req_if.valid <= 1'b1;
    req_if.command <= b.command;
    req_if.x_pos <= b.x_pos;
    req_if.y_pos <= b.y_pos;
    req_if.z_pos <= b.z_pos;
    req_if.x_extent <= b.x_extent;
    req_if.y_extent <= b.y_extent;
    req_if.z_extent <= b.z_extent;
    @(posedge clk_i);
    while (!req_if.ready) @(posedge clk_i);
    find_neighbors(b, hits);
    if (b.command == CMD_CLEAR) begin
      clears_sent++;
    end else begin
      adds_sent++;
      if (hits[0].full_error) full_seen++;
      if (hits[0].found) pairs_seen += hits.size();
      if (hits.size() > widest_item && hits[0].found) widest_item = hits.size();
    end
    if (typed) begin
      if (b.command == CMD_ADD) expected_results.insert(expected_results.size(), want);
    end else begin
      foreach (hits[k]) expected_results.insert(expected_results.size(), hits[k]);
    end
  endtask

  // Called right after an accepted item; always waits on the clock before it checks the queue.
  task automatic drain_results();
    req_if.valid <= 1'b0;
    do @(posedge clk_i); while (expected_results.size() != 0);
  endtask

  initial begin
    pair_result_t got;
    int           taken;
    res_if.ready = 1'b0;
    taken = 0;
    calm_sink = 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      int unsigned stall;
      stall = calm_sink ? 0 : $urandom_range(0, 5);
      if (stall != 0) begin
        res_if.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      res_if.ready <= 1'b1;
      @(posedge clk_i);
      while (!res_if.valid) @(posedge clk_i);
      got.new_index = res_if.new_index;
      got.other_index = res_if.other_index;
      got.found = res_if.found;
      got.full_error = res_if.full_error;
      got.last = res_if.last;
      check_result(got);
      taken++;
      if (taken % 48 == 0) calm_sink = ($urandom_range(0, 3) == 0);
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (req_if.valid && req_if.ready) || (res_if.valid && res_if.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= IDLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    stim_row_t    directed_rows[$];
    pair_result_t none;
    box_req_t     b;
    int           random_adds;
    int           style;
    int           len;
    bit           first_pause;

    none = '0;
    quiet_cycles = 0;
    mismatches = 0;
    stored_boxes = 0;
    calm_sender = 1'b0;
    rst_ni = 1'b0;
    req_if.valid = 1'b0;
    req_if.command = CMD_ADD;
    req_if.x_pos = '0;
    req_if.y_pos = '0;
    req_if.z_pos = '0;
    req_if.x_extent = '0;
    req_if.y_extent = '0;
    req_if.z_extent = '0;

    directed_rows.insert(directed_rows.size(),
        stim_row_t'{mk_box(CMD_ADD, 0, 0, 0, 0, 0, 0), 1, 1'b1,
                    mk_result(0, 0, 1'b0, 1'b0, 1'b1)});
    directed_rows.insert(directed_rows.size(),
        stim_row_t'{mk_box(CMD_ADD, 0, 0, 0, 0, 0, 0), 1, 1'b1,
                    mk_result(1, 0, 1'b1, 1'b0, 1'b1)});
    directed_rows.insert(directed_rows.size(),
        stim_row_t'{mk_box(CMD_ADD, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                           31'h7FFF_FFFF, 31'h7FFF_FFFF, 31'h7FFF_FFFF), 1, 1'b1,
                    mk_result(2, 0, 1'b0, 1'b0, 1'b1)});
    directed_rows.insert(directed_rows.size(),
        stim_row_t'{mk_box(CMD_ADD, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                           31'h7FFF_FFFF, 31'h7FFF_FFFF, 31'h7FFF_FFFF), 1, 1'b1,
                    mk_result(3, 0, 1'b0, 1'b0, 1'b1)});
    // Corner contact with the point boxes and with the far negative box.
    directed_rows.insert(directed_rows.size(),
        stim_row_t'{mk_box(CMD_ADD, -1, -1, -1, 1, 1, 1), 1, 1'b0, none});
    // Face contact.
    directed_rows.insert(directed_rows.size(),
        stim_row_t'{mk_box(CMD_ADD, 0, -3, -2, 5, 3, 2), 1, 1'b0, none});
    directed_rows.insert(directed_rows.size(),
        stim_row_t'{mk_box(CMD_ADD, 1, 0, 0, 0, 0, 0), 1, 1'b0, none});
    directed_rows.insert(directed_rows.size(),
        stim_row_t'{mk_box(CMD_ADD, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                           0, 0, 0), 1, 1'b0, none});
    directed_rows.insert(directed_rows.size(),
        stim_row_t'{mk_box(CMD_CLEAR, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                           31'h7FFF_FFFF, 31'h7FFF_FFFF, 31'h7FFF_FFFF), 1, 1'b1,
                    none});
    directed_rows.insert(directed_rows.size(),
        stim_row_t'{mk_box(CMD_ADD, 10, 10, 10, 31'h7FFF_FFFF, 31'h7FFF_FFFF,
                           31'h7FFF_FFFF), 1, 1'b1,
                    mk_result(0, 0, 1'b0, 1'b0, 1'b1)});
    // Identical boxes fill the set; the last one touches all 31 others.
    directed_rows.insert(directed_rows.size(),
        stim_row_t'{mk_box(CMD_ADD, 10, 10, 10, 31'h7FFF_FFFF, 31'h7FFF_FFFF,
                           31'h7FFF_FFFF), MAX_SLOTS - 1, 1'b0, none});
    directed_rows.insert(directed_rows.size(),
        stim_row_t'{mk_box(CMD_ADD, 5, 5, 5, 1, 1, 1), 1, 1'b1,
                    mk_result(0, 0, 1'b0, 1'b1, 1'b1)});
    directed_rows.insert(directed_rows.size(),
        stim_row_t'{mk_box(CMD_CLEAR, 0, 0, 0, 0, 0, 0), 1, 1'b1, none});
    directed_rows.insert(directed_rows.size(),
        stim_row_t'{mk_box(CMD_ADD, 0, 0, 0, 0, 0, 0), 1, 1'b1,
                    mk_result(0, 0, 1'b0, 1'b0, 1'b1)});

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[r]) begin
      repeat (directed_rows[r].reps) begin
        send_box(directed_rows[r].box, directed_rows[r].typed, directed_rows[r].want);
      end
    end

    random_adds = 0;
    first_pause = 1'b1;
    while (random_adds < RANDOM_ADDS) begin
      calm_sender = ($urandom_range(0, 4) == 0);
      if ($urandom_range(0, 3) != 0) begin
        b = random_box(0);
        b.command = CMD_CLEAR;
        send_box(b, 1'b0, none);
      end
      style = $urandom_range(0, 9);
      style = (style == 0) ? 0 : (style <= 4) ? 1 : (style <= 7) ? 2 : 3;
      len = $urandom_range(1, 40);
      for (int k = 0; k < len; k++) begin
        send_box(random_box(($urandom_range(0, 7) == 0) ? 0 : style), 1'b0, none);
        random_adds++;
      end
      if (first_pause || $urandom_range(0, 3) == 0) begin
        drain_results();
        first_pause = 1'b0;
      end
    end

    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk_i);

    $display("Sent %0d adds and %0d clears; checked %0d results.", adds_sent, clears_sent,
             results_checked);
    $display("Neighbor pairs %0d, refused adds %0d, most pairs from one add %0d.",
             pairs_seen, full_seen, widest_item);
    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
